// File: src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Default number of fraction bits kept for the hue fraction.
    localparam int FRAC_BITS_DEF = 16;

    // Full scale of saturation and brightness (1.0).
    localparam logic [15:0] UNIT16 = 16'hFFFF;

    // Channel divisor after the 2^FRAC_BITS shift: 257 * 65535.
    localparam logic [32:0] KDIV = 33'd16842495;

    // floor(2^40 / KDIV): reciprocal for the quotient estimate.
    localparam logic [15:0] RECIP = 16'd65281;

    // Hue sectors, one per sixth of a turn.
    typedef enum logic [2:0] {
        SECT_R_Y = 3'd0,
        SECT_Y_G = 3'd1,
        SECT_G_C = 3'd2,
        SECT_C_B = 3'd3,
        SECT_B_M = 3'd4,
        SECT_M_R = 3'd5
    } sector_t;

endpackage

// File: src/hsv2rgb_hsv_if.sv
`timescale 1ns / 1ps

interface hsv2rgb_hsv_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// File: src/hsv2rgb_rgb_if.sv
`timescale 1ns / 1ps

interface hsv2rgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps

// HSV to RGB converter. Takes one HSV pixel (16-bit hue as a fraction of a
// turn, 16-bit saturation and brightness with 65535 as full scale) and returns
// one 8-bit RGB pixel, each channel rounded to nearest with halves up. The
// datapath is a five-stage pipeline: a request is accepted every clock while
// the output is not stalled. Each stage holds its own valid bit, so
// back-pressure on rgb only stops the stages that are full; hsv.ready drops
// only when all five stages hold a pixel and the output is not taken.
// FRAC_BITS (8..24) sets the precision of the hue fraction and the width of
// the multipliers in stages two and three.
module hsv_to_rgb_converter_top #(
    parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hsv2rgb_hsv_if.sink          hsv,
    hsv2rgb_rgb_if.source        rgb
);

    localparam int LANES  = 3;
    localparam int LANE_V = 0;
    localparam int LANE_M = 1;
    localparam int LANE_X = 2;
    localparam int TW     = 16 + FRAC_BITS;   // width of the channel factor
    localparam int AW     = 33 + FRAC_BITS;   // width of factor * brightness + rounding

    localparam logic [FRAC_BITS:0] ONE_G    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [TW-1:0]      T_FULL   = {hsv2rgb_pkg::UNIT16, {FRAC_BITS{1'b0}}};
    localparam logic [AW-1:0]      ROUND_C  = AW'(hsv2rgb_pkg::KDIV) << (FRAC_BITS - 1);
    localparam logic [33:0]        KDIV2    = {hsv2rgb_pkg::KDIV, 1'b0};

    // stage valid bits and per-stage advance
    logic [5:1] valid_reg;
    logic [5:1] adv;

    always_comb
    begin
        adv[5] = !valid_reg[5] || rgb.ready;
        for (int k = 4; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign hsv.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= hsv.valid;
            end
            for (int k = 2; k <= 5; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: sector and fraction ----------------
    logic [18:0]          h6;
    logic [23:0]          w24;
    logic [FRAC_BITS-1:0] f0;
    logic [FRAC_BITS:0]   g0;
    hsv2rgb_pkg::sector_t sect0;

    assign h6    = {3'b000, hsv.hue} * 19'd6;
    assign w24   = {h6[15:0], 8'h00};
    assign f0    = w24[23 -: FRAC_BITS];
    assign sect0 = hsv2rgb_pkg::sector_t'(h6[18:16]);
    // odd sectors fall with f, even sectors rise
    assign g0    = h6[16] ? {1'b0, f0} : (ONE_G - {1'b0, f0});

    hsv2rgb_pkg::sector_t sect1_reg;
    logic [FRAC_BITS:0]   g1_reg;
    logic [15:0]          sat1_reg;
    logic [15:0]          val1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sect1_reg <= sect0;
            g1_reg    <= g0;
            sat1_reg  <= hsv.saturation;
            val1_reg  <= hsv.brightness;
        end
    end

    // ---------------- stage 2: channel factors ----------------
    logic [TW:0]   sg1;
    logic [TW-1:0] t1 [LANES];

    assign sg1        = (TW + 1)'(sat1_reg) * (TW + 1)'(g1_reg);
    assign t1[LANE_V] = T_FULL;
    assign t1[LANE_M] = {hsv2rgb_pkg::UNIT16 - sat1_reg, {FRAC_BITS{1'b0}}};
    assign t1[LANE_X] = T_FULL - sg1[TW-1:0];

    hsv2rgb_pkg::sector_t sect2_reg;
    logic [15:0]          val2_reg;
    logic [TW-1:0]        t2_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sect2_reg <= sect1_reg;
            val2_reg  <= val1_reg;
            for (int i = 0; i < LANES; i++)
            begin
                t2_reg[i] <= t1[i];
            end
        end
    end

    // ---------------- stage 3: scale by brightness, add half ----------------
    logic [AW-1:0] a2 [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            a2[i] = AW'(val2_reg) * AW'(t2_reg[i]) + ROUND_C;
        end
    end

    hsv2rgb_pkg::sector_t sect3_reg;
    logic [32:0]          b3_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sect3_reg <= sect2_reg;
            for (int i = 0; i < LANES; i++)
            begin
                b3_reg[i] <= a2[i][FRAC_BITS +: 33];
            end
        end
    end

    // ---------------- stage 4: quotient estimate ----------------
    logic [40:0] p3 [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            p3[i] = 41'(b3_reg[i][32:8]) * 41'(hsv2rgb_pkg::RECIP);
        end
    end

    hsv2rgb_pkg::sector_t sect4_reg;
    logic [32:0]          b4_reg  [LANES];
    logic [7:0]           qe4_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            sect4_reg <= sect3_reg;
            for (int i = 0; i < LANES; i++)
            begin
                b4_reg[i]  <= b3_reg[i];
                qe4_reg[i] <= p3[i][39:32];
            end
        end
    end

    // ---------------- stage 5: correction, clamp, channel order ----------------
    logic [32:0] rem4  [LANES];
    logic [8:0]  q4    [LANES];
    logic [7:0]  byte4 [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rem4[i]  = b4_reg[i] - 33'(qe4_reg[i]) * hsv2rgb_pkg::KDIV;
            // estimate is low by at most one
            q4[i]    = {1'b0, qe4_reg[i]} + 9'(rem4[i] >= hsv2rgb_pkg::KDIV);
            byte4[i] = q4[i][8] ? 8'hFF : q4[i][7:0];
        end
    end

    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    always_comb
    begin
        unique case (sect4_reg)
            hsv2rgb_pkg::SECT_R_Y:
            begin
                red_next   = byte4[LANE_V];
                green_next = byte4[LANE_X];
                blue_next  = byte4[LANE_M];
            end
            hsv2rgb_pkg::SECT_Y_G:
            begin
                red_next   = byte4[LANE_X];
                green_next = byte4[LANE_V];
                blue_next  = byte4[LANE_M];
            end
            hsv2rgb_pkg::SECT_G_C:
            begin
                red_next   = byte4[LANE_M];
                green_next = byte4[LANE_V];
                blue_next  = byte4[LANE_X];
            end
            hsv2rgb_pkg::SECT_C_B:
            begin
                red_next   = byte4[LANE_M];
                green_next = byte4[LANE_X];
                blue_next  = byte4[LANE_V];
            end
            hsv2rgb_pkg::SECT_B_M:
            begin
                red_next   = byte4[LANE_X];
                green_next = byte4[LANE_M];
                blue_next  = byte4[LANE_V];
            end
            default:
            begin
                red_next   = byte4[LANE_V];
                green_next = byte4[LANE_M];
                blue_next  = byte4[LANE_X];
            end
        endcase
    end

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = valid_reg[5];
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

`ifndef SYNTHESIS
    // reciprocal estimate for the X lane must be within one of the true quotient
    a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> ({1'b0, rem4[LANE_X]} < KDIV2))
        else $error("quotient estimate off by more than one");

    // rounded channel never needs the clamp
    a_no_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (q4[LANE_X][8] == 1'b0 && q4[LANE_M][8] == 1'b0
                          && q4[LANE_V][8] == 1'b0))
        else $error("channel quotient above 255");

    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv.ready |-> (valid_reg == 5'b11111 && !rgb.ready))
        else $error("input stalled with a free stage");

    // a held result keeps its value until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && !rgb.ready) |=> (rgb.valid && $stable(red_reg)
                                       && $stable(green_reg) && $stable(blue_reg)))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/hsv_to_rgb_converter_top_test.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_test;

    localparam int FRAC_W     = hsv2rgb_pkg::FRAC_BITS_DEF;
    localparam int RAND_ITEMS = 1600;
    localparam int CALM_ITEMS = 200;
    localparam int DIR_ROWS   = 22;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_px_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] bri;
        logic        known;
        rgb_px_t     want;
    } dir_row_t;

    // Rows with known = 1 carry a hand-checked color; the rest go through the predictor.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd0,     16'd65535, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'd0,     16'd65535, 16'd65535, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'd21846, 16'd65535, 16'd65535, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{16'd43691, 16'd65535, 16'd65535, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{16'd32768, 16'd65535, 16'd65535, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'd65535, 16'd65535, 16'd0,     1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 16'd0,     16'd65535, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'd65535, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10922, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10923, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd21845, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd43690, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd54613, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd54614, 16'd65535, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd32768, 16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd0,     16'd32768, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd0,     16'd1,     1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 16'd1,     16'd65535, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd12345, 16'd65535, 16'd32767, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic clk;
    logic rst_n;
    logic calm;
    int   err_count;

    rgb_px_t expected_rgb [$];

    hsv2rgb_hsv_if hsv_ch ();
    hsv2rgb_rgb_if rgb_ch ();

    hsv_to_rgb_converter_top #(
        .FRAC_BITS (FRAC_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Channel numerator over 65535*65535*2^FRAC_W, rounded half up, clipped.
    function automatic logic [7:0] chan_byte(input logic [63:0] num);
        logic [63:0] den;
        logic [63:0] q;
        den = (64'd65535 * 64'd65535) << FRAC_W;
        q   = (num * 64'd255 + (den >> 1)) / den;
        if (q > 64'd255)
            q = 64'd255;
        return q[7:0];
    endfunction

    function automatic rgb_px_t predict_rgb(input logic [15:0] h, s, b);
        logic [63:0]          hu, sa, br, h6, frac16, f, g, one;
        logic [7:0]           bv, bm, bx;
        hsv2rgb_pkg::sector_t sect;
        rgb_px_t              px;
        hu     = {48'd0, h};
        sa     = {48'd0, s};
        br     = {48'd0, b};
        h6     = hu * 64'd6;
        sect   = hsv2rgb_pkg::sector_t'(h6[18:16]);
        frac16 = h6 & 64'hFFFF;
        one    = 64'd1 << FRAC_W;
        f      = (frac16 << 8) >> (24 - FRAC_W);
        g      = h6[16] ? f : (one - f);
        bv     = chan_byte((br * 64'd65535) << FRAC_W);
        bm     = chan_byte((br * (64'd65535 - sa)) << FRAC_W);
        bx     = chan_byte(br * ((64'd65535 << FRAC_W) - sa * g));
        case (sect)
            hsv2rgb_pkg::SECT_R_Y: px = '{bv, bx, bm};
            hsv2rgb_pkg::SECT_Y_G: px = '{bx, bv, bm};
            hsv2rgb_pkg::SECT_G_C: px = '{bm, bv, bx};
            hsv2rgb_pkg::SECT_C_B: px = '{bm, bx, bv};
            hsv2rgb_pkg::SECT_B_M: px = '{bx, bm, bv};
            default:               px = '{bv, bm, bx};
        endcase
        return px;
    endfunction

    // Mostly near the ends of the range, else anything.
    function automatic logic [15:0] pick_level();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom_range(0, 3));
            3:       v = 16'hFFFF - 16'($urandom_range(0, 3));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic idle_source(input int n);
        repeat (n)
        begin
            @(negedge clk);
            hsv_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_pixel(input logic [15:0] h, s, b, input logic known,
                              input rgb_px_t want);
        @(negedge clk);
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= h;
        hsv_ch.saturation <= s;
        hsv_ch.brightness <= b;
        @(posedge clk);
        while (!hsv_ch.ready)
            @(posedge clk);
        expected_rgb.push_back(known ? want : predict_rgb(h, s, b));
    endtask

    task automatic check_chan(input string name, input logic [7:0] want, got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Request source
    initial
    begin
        int          gap_pct;
        int          k;
        logic [15:0] h, s, b;
        rgb_px_t     dummy;
        dummy             = '0;
        gap_pct           = 0;
        err_count         = 0;
        calm              = 1'b0;
        rst_n             = 1'b0;
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i % 4 == 3)
                idle_source($urandom_range(1, 18));
            send_pixel(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].bri,
                       DIRECTED[i].known, DIRECTED[i].want);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 100 == 0)
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            if (i >= RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 99) < gap_pct)
                idle_source($urandom_range(1, 18));

            case ($urandom_range(0, 9))
                6, 7:
                begin
                    // around a sector boundary, including the wrap
                    k = $urandom_range(0, 6);
                    h = 16'((k * 65536) / 6 + $urandom_range(0, 6) - 3);
                end
                8:       h = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                default: h = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       s = 16'd0;
                1, 2:    s = pick_level();
                default: s = 16'($urandom);
            endcase
            b = ($urandom_range(0, 3) == 0) ? pick_level() : 16'($urandom);
            send_pixel(h, s, b, 1'b0, dummy);
        end

        @(negedge clk);
        hsv_ch.valid <= 1'b0;

        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (err_count == 0 && expected_rgb.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result sink with random back-pressure bursts
    initial
    begin
        int n;
        rgb_ch.ready = 1'b0;
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 18);
                repeat (n)
                begin
                    @(negedge clk);
                    rgb_ch.ready <= 1'b0;
                end
            end
            else
            begin
                @(negedge clk);
                rgb_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        rgb_px_t exp_px;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                $display("%0t ns: unexpected pixel, expected none, actual %0d %0d %0d",
                         $time, rgb_ch.red, rgb_ch.green, rgb_ch.blue);
                err_count++;
            end
            else
            begin
                exp_px = expected_rgb.pop_front();
                check_chan("red",   exp_px.red,   rgb_ch.red);
                check_chan("green", exp_px.green, rgb_ch.green);
                check_chan("blue",  exp_px.blue,  rgb_ch.blue);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
